// ===== sv/src_pkg.sv =====
`timescale 1ns / 1ps

package src_pkg;

    // Default sizes of the block.
    localparam int CHANNELS_DEF = 4;
    localparam int SAMPLES_DEF  = 5;

    // Fixed field widths.
    localparam int CH_W       = 2;
    localparam int SAMPLE_W   = 10;
    localparam int AVG_W      = 10;
    localparam int RATIO_W    = 16;
    localparam int CLASS_W    = 3;
    localparam int ENABLE_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shared divider sizes: the dividend holds 1023 * 1000, the divisor holds 1024.
    localparam int DIV_W = 20;
    localparam int DVS_W = 11;

    // Arithmetic constants.
    localparam logic [DIV_W-1:0]   RATIO_SCALE = 20'd1000;
    localparam logic [DVS_W-1:0]   FULL_SCALE  = 11'd1024;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT   = 3'd4;

    // Register reset values.
    localparam logic [ENABLE_W-1:0] ENABLE_RST       = 4'd15;
    localparam logic [RATIO_W-1:0]  SHORT_LIMIT_RST  = 16'd480;
    localparam logic [RATIO_W-1:0]  HIGH_FLOOR_RST   = 16'd750;
    localparam logic [RATIO_W-1:0]  HIGH_LIMIT_RST   = 16'd1220;
    localparam logic [RATIO_W-1:0]  NORMAL_LIMIT_RST = 16'd1680;

    // Sensor class codes.
    localparam logic [CLASS_W-1:0] CLS_NORMAL = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_LOW    = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_HIGH   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_OPEN   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_SHORT  = 3'd5;

    // Classification thresholds.
    typedef struct packed {
        logic [RATIO_W-1:0] short_limit;
        logic [RATIO_W-1:0] high_floor;
        logic [RATIO_W-1:0] high_limit;
        logic [RATIO_W-1:0] normal_limit;
    } src_thresh_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } src_div_status_t;

endpackage

// ===== sv/sensor_resistance_classifier_top.sv =====
`timescale 1ns / 1ps
// Timing: a sample that does not complete an average is absorbed in its accept cycle.
// A completing sample then passes the sequencer states in order: the mean by reciprocal
// multiplication, loading of the divider, 20 serial divider steps for the ratio, capture
// of the ratio and loading of the output register. Reset clears sums, counts and state.
// Throughput: one request per cycle while averaging; s_ready stays low from a completing
// sample until its result is loaded, longer while m_ready holds off.

module sensor_resistance_classifier_top #(
    parameter int CHANNELS = src_pkg::CHANNELS_DEF,
    parameter int SAMPLES  = src_pkg::SAMPLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [src_pkg::CH_W-1:0]        s_channel,
    input  logic [src_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [src_pkg::CH_W-1:0]        m_out_channel,
    output logic [src_pkg::AVG_W-1:0]       m_average,
    output logic [src_pkg::RATIO_W-1:0]     m_resistance,
    output logic [src_pkg::CLASS_W-1:0]     m_sensor_class,
    input  logic                            cfg_we,
    input  logic [src_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [src_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import src_pkg::*;

    // Only channels reachable by the channel field get storage.
    localparam int CH_DEPTH = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int IDX_W    = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
    localparam int SUM_W    = $clog2(SAMPLES * 1023 + 1);
    localparam int CNT_W    = $clog2(SAMPLES + 1);

    // Mean by reciprocal multiplication: exact for every sum below 2**SUM_W.
    localparam int MEAN_SH = SUM_W + $clog2(SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'(((64'd1 << MEAN_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MEAN      = 3'd1;
    localparam logic [2:0] ST_MUL       = 3'd2;
    localparam logic [2:0] ST_DIV_RATIO = 3'd3;
    localparam logic [2:0] ST_OUT       = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [ENABLE_W-1:0]  enable_reg;
    src_thresh_t          thresh_reg;
    logic [SUM_W-1:0]     sum_reg [CH_DEPTH];
    logic [CNT_W-1:0]     count_reg [CH_DEPTH];
    logic [CH_W-1:0]      ch_reg;
    logic [SUM_W-1:0]     sum_hold_reg;
    logic [AVG_W-1:0]     avg_reg;
    logic [RATIO_W-1:0]   ratio_reg;
    logic                 m_valid_reg;
    logic [CH_W-1:0]      m_channel_reg;
    logic [AVG_W-1:0]     m_average_reg;
    logic [RATIO_W-1:0]   m_ratio_reg;
    logic [CLASS_W-1:0]   m_class_reg;

    logic                 in_fire;
    logic                 ch_ok;
    logic [IDX_W-1:0]     idx;
    logic [SUM_W-1:0]     sum_add;
    logic [CNT_W-1:0]     count_inc;
    logic                 full;
    logic                 avg_start;
    logic [PROD_W-1:0]    mean_prod;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    src_div_status_t      div_st;
    logic [DIV_W-1:0]     div_quotient;
    logic [RATIO_W-1:0]   ratio_sat;
    logic [CLASS_W-1:0]   cls;
    logic                 out_load;

    // Input request qualification and running sum update.
    always_comb begin
        in_fire   = s_valid && s_ready;
        idx       = s_channel[IDX_W-1:0];
        ch_ok     = (int'(s_channel) < CH_DEPTH) && enable_reg[s_channel];
        sum_add   = sum_reg[idx] + SUM_W'(s_sample);
        count_inc = count_reg[idx] + 1'b1;
        full      = (count_inc == CNT_W'(SAMPLES));
        avg_start = in_fire && ch_ok && full;
    end

    // Mean of the held sum, then the shared divider feed for the resistance ratio.
    always_comb begin
        mean_prod    = PROD_W'(sum_hold_reg) * PROD_W'(MEAN_RECIP);
        div_start    = (state_reg == ST_MUL);
        div_dividend = DIV_W'(avg_reg) * RATIO_SCALE;
        div_divisor  = FULL_SCALE - DVS_W'(avg_reg);
        ratio_sat = (|div_quotient[DIV_W-1:RATIO_W]) ? RATIO_MAX
                                                     : div_quotient[RATIO_W-1:0];
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (avg_start) state_next = ST_MEAN;
            end
            ST_MEAN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV_RATIO;
            end
            ST_DIV_RATIO: begin
                if (div_st.done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and per-channel accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            enable_reg  <= ENABLE_RST;
            thresh_reg  <= '{SHORT_LIMIT_RST, HIGH_FLOOR_RST,
                             HIGH_LIMIT_RST, NORMAL_LIMIT_RST};
            for (int i = 0; i < CH_DEPTH; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNEL_ENABLE: enable_reg              <= cfg_wdata[ENABLE_W-1:0];
                    REG_SHORT_LIMIT:    thresh_reg.short_limit  <= cfg_wdata[RATIO_W-1:0];
                    REG_HIGH_FLOOR:     thresh_reg.high_floor   <= cfg_wdata[RATIO_W-1:0];
                    REG_HIGH_LIMIT:     thresh_reg.high_limit   <= cfg_wdata[RATIO_W-1:0];
                    REG_NORMAL_LIMIT:   thresh_reg.normal_limit <= cfg_wdata[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire && ch_ok) begin
                if (full) begin
                    sum_reg[idx]   <= '0;
                    count_reg[idx] <= '0;
                end else begin
                    sum_reg[idx]   <= sum_add;
                    count_reg[idx] <= count_inc;
                end
            end
        end
    end

    // Working values and the output register.
    always_ff @(posedge aclk) begin
        if (avg_start) begin
            ch_reg       <= s_channel;
            sum_hold_reg <= sum_add;
        end
        if (state_reg == ST_MEAN) begin
            avg_reg <= mean_prod[MEAN_SH +: AVG_W];
        end
        if (state_reg == ST_DIV_RATIO && div_st.done) begin
            ratio_reg <= ratio_sat;
        end
        if (out_load) begin
            m_channel_reg <= ch_reg;
            m_average_reg <= avg_reg;
            m_ratio_reg   <= ratio_reg;
            m_class_reg   <= cls;
        end
    end

    src_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st),
        .quotient (div_quotient)
    );

    src_classifier u_classifier (
        .ratio        (ratio_reg),
        .thresh       (thresh_reg),
        .sensor_class (cls)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_channel  = m_channel_reg;
    assign m_average      = m_average_reg;
    assign m_resistance   = m_ratio_reg;
    assign m_sensor_class = m_class_reg;

`ifndef ASSERT_OFF
    // The divider is never restarted while it is still iterating.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    // A divider completion only arrives while the sequencer waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV_RATIO))
        else $error("divider done outside the divide state");

    // A new result only appears from the output state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    // Every reported class is one of the five codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_class_reg >= CLS_NORMAL && m_class_reg <= CLS_SHORT))
        else $error("invalid sensor class reported");
`endif

endmodule

// ===== sv/src_divider.sv =====
`timescale 1ns / 1ps

module src_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [src_pkg::DIV_W-1:0]     dividend,
    input  logic [src_pkg::DVS_W-1:0]     divisor,
    output src_pkg::src_div_status_t      status,
    output logic [src_pkg::DIV_W-1:0]     quotient
);
    import src_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    // Step counter and status.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== sv/src_classifier.sv =====
`timescale 1ns / 1ps

module src_classifier (
    input  logic [src_pkg::RATIO_W-1:0]  ratio,
    input  src_pkg::src_thresh_t         thresh,
    output logic [src_pkg::CLASS_W-1:0]  sensor_class
);
    import src_pkg::*;

    // The tests are checked in priority order; anything not caught is open.
    always_comb begin
        if (ratio > thresh.high_limit && ratio <= thresh.normal_limit) begin
            sensor_class = CLS_NORMAL;
        end else if (ratio >= thresh.high_floor && ratio <= thresh.high_limit) begin
            sensor_class = CLS_HIGH;
        end else if (ratio > thresh.short_limit && ratio <= thresh.high_floor) begin
            sensor_class = CLS_LOW;
        end else if (ratio <= thresh.short_limit) begin
            sensor_class = CLS_SHORT;
        end else begin
            sensor_class = CLS_OPEN;
        end
    end

endmodule

// ===== sim/sensor_resistance_classifier_checker.sv =====
`timescale 1ns / 1ps

module sensor_resistance_classifier_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [src_pkg::CH_W-1:0]        s_channel,
    input  logic [src_pkg::SAMPLE_W-1:0]    s_sample,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [src_pkg::CH_W-1:0]        m_out_channel,
    input  logic [src_pkg::AVG_W-1:0]       m_average,
    input  logic [src_pkg::RATIO_W-1:0]     m_resistance,
    input  logic [src_pkg::CLASS_W-1:0]     m_sensor_class,
    input  logic                            cfg_we,
    input  logic [src_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [src_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                              readings_due,
    output int                              fail_count,
    output int                              readings_checked
);
    import src_pkg::*;

    localparam int SUM_W = 13;
    localparam int CNT_W = 3;

    // One classified reading as it leaves the block.
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [AVG_W-1:0]   average;
        logic [RATIO_W-1:0] resistance;
        logic [CLASS_W-1:0] sensor_class;
    } reading_t;

    logic [ENABLE_W-1:0] enable_mask;
    src_thresh_t         limits;
    logic [SUM_W-1:0]    chan_sum [CHANNELS_DEF];
    logic [CNT_W-1:0]    chan_count [CHANNELS_DEF];
    reading_t            pending_readings [$];

    // The class tests run in a fixed order, so overlapping limits resolve to the first hit.
    function automatic logic [CLASS_W-1:0] classify(input logic [RATIO_W-1:0] r);
        if (r > limits.high_limit && r <= limits.normal_limit) return CLS_NORMAL;
        if (r >= limits.high_floor && r <= limits.high_limit) return CLS_HIGH;
        if (r > limits.short_limit && r <= limits.high_floor) return CLS_LOW;
        if (r <= limits.short_limit) return CLS_SHORT;
        return CLS_OPEN;
    endfunction

    always @(posedge aclk) begin
        reading_t         want;
        logic [AVG_W-1:0] avg;
        int               wide;
        logic [RATIO_W-1:0] ratio;
        int               errs;

        errs = 0;
        if (!aresetn) begin
            enable_mask = ENABLE_RST;
            limits.short_limit = SHORT_LIMIT_RST;
            limits.high_floor = HIGH_FLOOR_RST;
            limits.high_limit = HIGH_LIMIT_RST;
            limits.normal_limit = NORMAL_LIMIT_RST;
            for (int c = 0; c < CHANNELS_DEF; c++) begin
                chan_sum[c] = '0;
                chan_count[c] = '0;
            end
            pending_readings.delete();
            fail_count <= 0;
            readings_checked <= 0;
        end else begin
            // Register writes; unknown indexes are ignored.
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNEL_ENABLE: enable_mask = cfg_wdata[ENABLE_W-1:0];
                    REG_SHORT_LIMIT:    limits.short_limit = cfg_wdata;
                    REG_HIGH_FLOOR:     limits.high_floor = cfg_wdata;
                    REG_HIGH_LIMIT:     limits.high_limit = cfg_wdata;
                    REG_NORMAL_LIMIT:   limits.normal_limit = cfg_wdata;
                    default: ;
                endcase
            end

            // Compare a delivered reading against the oldest prediction.
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("Reading on channel %0d with none expected", m_out_channel);
                    errs++;
                end else begin
                    want = pending_readings.pop_front();
                    if (m_out_channel !== want.channel) begin
                        $error("out_channel: expected %0d, got %0d", want.channel, m_out_channel);
                        errs++;
                    end
                    if (m_average !== want.average) begin
                        $error("average: expected %0d, got %0d", want.average, m_average);
                        errs++;
                    end
                    if (m_resistance !== want.resistance) begin
                        $error("resistance: expected %0d, got %0d",
                               want.resistance, m_resistance);
                        errs++;
                    end
                    if (m_sensor_class !== want.sensor_class) begin
                        $error("sensor_class: expected %0d, got %0d",
                               want.sensor_class, m_sensor_class);
                        errs++;
                    end
                end
                readings_checked <= readings_checked + 1;
            end

            // Accumulate an accepted request; a full set yields one reading.
            if (s_valid && s_ready && enable_mask[s_channel]) begin
                chan_sum[s_channel] = chan_sum[s_channel] + s_sample;
                chan_count[s_channel] = chan_count[s_channel] + 1'b1;
                if (chan_count[s_channel] == SAMPLES_DEF) begin
                    avg = AVG_W'(chan_sum[s_channel] / SAMPLES_DEF);
                    wide = (int'(avg) * int'(RATIO_SCALE)) / (int'(FULL_SCALE) - int'(avg));
                    ratio = (wide > int'(RATIO_MAX)) ? RATIO_MAX : RATIO_W'(wide);
                    want.channel = s_channel;
                    want.average = avg;
                    want.resistance = ratio;
                    want.sensor_class = classify(ratio);
                    pending_readings.push_back(want);
                    chan_sum[s_channel] = '0;
                    chan_count[s_channel] = '0;
                end
            end
            fail_count <= fail_count + errs;
        end
        readings_due <= pending_readings.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import src_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 136;
    localparam int NOISE_ITEMS    = 12;

    // Index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_channel = '0;
    logic [SAMPLE_W-1:0]   s_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CH_W-1:0]       m_out_channel;
    logic [AVG_W-1:0]      m_average;
    logic [RATIO_W-1:0]    m_resistance;
    logic [CLASS_W-1:0]    m_sensor_class;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int readings_due;
    int fail_count;
    int readings_checked;

    int                  idle_cycles = 0;
    int                  samples_sent = 0;
    int                  hold_requests = 0;
    int                  holds_served = 0;
    bit                  steady = 1'b0;
    logic [ENABLE_W-1:0] live_enable = ENABLE_RST;
    int                  levels [4];

    always #HALF_PERIOD aclk = ~aclk;

    sensor_resistance_classifier_top uut (.*);

    sensor_resistance_classifier_checker checker_i (.*);

    // Abort when the channels stay quiet for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_of(input int avg);
        int wide;
        wide = avg * 1000 / (1024 - avg);
        return (wide > 65535) ? RATIO_MAX : RATIO_W'(wide);
    endfunction

    // Steady sensors sit on one level so their averages land exactly on a limit.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 45) return SAMPLE_W'(levels[$urandom_range(0, 3)]);
        if (roll < 55) begin
            v = levels[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
            return (v < 0) ? '0 : (v > 1023) ? '1 : SAMPLE_W'(v);
        end
        if (roll < 65) return $urandom_range(0, 1) ? '1 : '0;
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    // Mostly present channels, with the odd request on an absent one.
    function automatic logic [CH_W-1:0] pick_channel();
        logic [CH_W-1:0] ch;
        ch = CH_W'($urandom_range(0, 3));
        if (live_enable != '0 && $urandom_range(0, 9) != 0)
            while (!live_enable[ch]) ch = CH_W'($urandom_range(0, 3));
        return ch;
    endfunction

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel <= ch;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Stop offering requests until every reading is back, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (readings_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Write every register; the enable carries junk in its unused upper bits.
    task automatic configure(input logic [ENABLE_W-1:0] en, input src_thresh_t lim);
        logic [CFG_DATA_W-1:0] raw;
        raw = CFG_DATA_W'($urandom);
        raw[ENABLE_W-1:0] = en;
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_CHANNEL_ENABLE, raw);
        write_reg(REG_SHORT_LIMIT, lim.short_limit);
        write_reg(REG_HIGH_FLOOR, lim.high_floor);
        write_reg(REG_HIGH_LIMIT, lim.high_limit);
        write_reg(REG_NORMAL_LIMIT, lim.normal_limit);
        cfg_we <= 1'b0;
        live_enable = en;
    endtask

    task automatic run_phase(input int quota);
        int              counted;
        logic [CH_W-1:0] ch;
        counted = 0;
        while (counted < quota) begin
            ch = pick_channel();
            if (live_enable[ch]) counted++;
            send_sample(ch, pick_sample());
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Interleaved channels under the reset limits: open at saturation, short at zero,
        // a truncated mean classed high, then normal, then low.
        for (int k = 0; k < 5; k++) begin
            send_sample(2'd0, 10'd1023);
            send_sample(2'd1, 10'd0);
            send_sample(2'd2, (k == 4) ? 10'd514 : 10'd512);
            send_sample(2'd3, 10'd580);
        end
        repeat (5) send_sample(2'd0, 10'd350);
        drain();

        // Phase 0 zero limits, 1 full-scale limits with a long output stall, 2 no sensors,
        // 3 limits out of order, 4 reset limits without idling, then random ordered limits.
        for (int p = 0; p < PHASES; p++) begin
            logic [ENABLE_W-1:0] en;
            src_thresh_t         lim;
            int                  t;

            for (int i = 0; i < 4; i++) levels[i] = $urandom_range(0, 1023);
            if (p != 3) begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3 - i; j++)
                        if (levels[j] > levels[j + 1]) begin
                            t = levels[j];
                            levels[j] = levels[j + 1];
                            levels[j + 1] = t;
                        end
            end
            lim.short_limit = ratio_of(levels[0]);
            lim.high_floor = ratio_of(levels[1]);
            lim.high_limit = ratio_of(levels[2]);
            lim.normal_limit = ratio_of(levels[3]);
            en = ENABLE_W'($urandom_range(1, 15));
            steady = (p == 4);
            case (p)
                0: begin
                    lim = '0;
                    en = 4'h5;
                end
                1: begin
                    lim = '1;
                    en = '1;
                end
                2: en = '0;
                4: begin
                    lim.short_limit = SHORT_LIMIT_RST;
                    lim.high_floor = HIGH_FLOOR_RST;
                    lim.high_limit = HIGH_LIMIT_RST;
                    lim.normal_limit = NORMAL_LIMIT_RST;
                    en = ENABLE_RST;
                end
                default: ;
            endcase

            configure(en, lim);
            if (p == 1) hold_requests <= hold_requests + 1;
            if (en == '0) begin
                repeat (NOISE_ITEMS) send_sample(pick_channel(), pick_sample());
            end else if (p == 6) begin
                run_phase(PHASE_ITEMS / 2);
                drain();
                run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_phase(PHASE_ITEMS);
            end
            drain();
        end

        $display("Sent %0d samples over %0d limit settings; %0d readings compared.",
                 samples_sent, PHASES + 1, readings_checked);
        $display("Covered zero, full-scale, reversed and reset limits, absent channels, "
                 , "masked enables and a long output stall.");
        if (fail_count == 0 && readings_due == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
